// ===== sv/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// Types, codes and move tables for the servo move sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package sms_pkg;

  localparam int unsigned MaxSeqSteps = 4;

  localparam int unsigned AngleW  = 9;
  localparam int unsigned TolW    = 10;
  localparam int unsigned TickW   = 16;
  localparam int unsigned MeasW   = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 24;

  localparam logic [CfgIdxW-1:0] CfgGripOpen   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgGripClosed = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgSlideBot   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgSlideTop   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgSlideMid   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTolerance  = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgTimeout    = 3'd6;

  localparam logic KindCommand = 1'b0;
  localparam logic KindTick    = 1'b1;

  localparam logic ServoGripper = 1'b0;
  localparam logic ServoSlider  = 1'b1;

  typedef enum logic [1:0] {
    SeqTake     = 2'd0,
    SeqTakeLast = 2'd1,
    SeqUnload   = 2'd2,
    SeqNone     = 2'd3
  } seq_e;

  typedef enum logic [2:0] {
    ExIdle     = 3'd0,
    ExActive   = 3'd1,
    ExDone     = 3'd2,
    ExRetries  = 3'd3,
    ExWrongPos = 3'd4
  } exec_state_e;

  typedef enum logic [2:0] {
    CkWaiting   = 3'd0,
    CkActive    = 3'd1,
    CkConfirmed = 3'd2,
    CkReadFail  = 3'd3,
    CkTimeout   = 3'd4
  } check_state_e;

  typedef enum logic [2:0] {
    MvOpen    = 3'd0,
    MvClose   = 3'd1,
    MvLower   = 3'd2,
    MvLift    = 3'd3,
    MvLiftMid = 3'd4
  } move_e;

  typedef struct packed {
    logic [1:0]        step_position;
    logic [AngleW-1:0] move_target;
    logic              servo_select;
    logic              move_issued;
    check_state_e      checker_status;
    exec_state_e       executor_status;
  } result_t;

  function automatic move_e seq_move(input seq_e seq, input logic [1:0] step);
    move_e mv;
    mv = MvOpen;
    unique case (seq)
      SeqTake: begin
        unique case (step)
          2'd0: mv = MvOpen;
          2'd1: mv = MvLower;
          2'd2: mv = MvClose;
          default: mv = MvLift;
        endcase
      end
      SeqTakeLast: begin
        unique case (step)
          2'd0: mv = MvOpen;
          2'd1: mv = MvLower;
          2'd2: mv = MvClose;
          default: mv = MvLiftMid;
        endcase
      end
      default: begin
        unique case (step)
          2'd0: mv = MvLower;
          2'd1: mv = MvOpen;
          2'd2: mv = MvLift;
          default: mv = MvOpen;
        endcase
      end
    endcase
    return mv;
  endfunction

  function automatic logic [3:0] seq_length(input seq_e seq);
    logic [3:0] n;
    unique case (seq)
      SeqTake, SeqTakeLast: n = 4'd4;
      default: n = 4'd3;
    endcase
    if (n > 4'(MaxSeqSteps)) n = 4'(MaxSeqSteps);
    return n;
  endfunction

endpackage

`default_nettype wire

// ===== sv/servo_move_sequencer.sv =====
// ----------------------------------------------------------------------------
// servo_move_sequencer
// Gripper/slider move sequencer with position checker, one result per item.
// ----------------------------------------------------------------------------
// The result is registered and valid in the cycle after the item is accepted.
// Throughput: 1 item per cycle; input ready while the result register is
//   empty or being taken in the same cycle.
// Reset: executor idle, checker waiting, angles 0, tolerance 16,
//   timeout 100 ticks, no result pending.
`default_nettype none

module servo_move_sequencer (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [sms_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  wire logic [sms_pkg::CfgW-1:0]    cfg_data_i,
  input  wire logic                        s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] sequence_select, [2] pre_read_ok, [3] set_ok, [4] check_read_ok,
  // [17:5] measured_angle, [23:18] zero
  input  wire logic [sms_pkg::InDataW-1:0] s_axis_tdata,
  // [0] kind
  input  wire logic                        s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  wire logic                        m_axis_tready,
  // [2:0] executor_status, [5:3] checker_status, [6] move_issued,
  // [7] servo_select, [16:8] move_target, [18:17] step_position, [23:19] zero
  output logic [sms_pkg::OutDataW-1:0]     m_axis_tdata
);

  import sms_pkg::*;

  logic [AngleW-1:0] grip_open_q, grip_closed_q, slide_bot_q, slide_top_q, slide_mid_q;
  logic [TolW-1:0]   tol_q;
  logic [TickW-1:0]  timeout_q;

  exec_state_e       exec_q, exec_d;
  seq_e              seq_q, seq_d;
  logic [1:0]        step_q, step_d;
  check_state_e      check_q, check_d;
  logic [AngleW-1:0] target_q, target_d;
  logic [TickW-1:0]  tick_q, tick_d;
  logic              servo_q, servo_d;

  logic              out_valid_q, out_valid_d;
  logic [1:0]        out_step_q;
  logic [AngleW-1:0] out_target_q;
  logic              out_servo_q, out_issued_q;
  check_state_e      out_check_q;
  exec_state_e       out_exec_q;
  logic              issued;

  logic              in_fire;
  logic              in_kind;
  logic [1:0]        in_sel;
  logic              in_pre_ok, in_set_ok, in_rd_ok;
  logic [MeasW-1:0]  in_meas;

  move_e             mv;
  logic              mv_servo;
  logic [AngleW-1:0] mv_target;
  logic signed [MeasW+1:0] diff;
  logic [MeasW:0]    abs_diff;

  assign in_kind   = s_axis_tuser;
  assign in_sel    = s_axis_tdata[1:0];
  assign in_pre_ok = s_axis_tdata[2];
  assign in_set_ok = s_axis_tdata[3];
  assign in_rd_ok  = s_axis_tdata[4];
  assign in_meas   = s_axis_tdata[17:5];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grip_open_q   <= '0;
      grip_closed_q <= '0;
      slide_bot_q   <= '0;
      slide_top_q   <= '0;
      slide_mid_q   <= '0;
      tol_q         <= TolW'(16);
      timeout_q     <= TickW'(100);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgGripOpen:   grip_open_q   <= cfg_data_i[AngleW-1:0];
        CfgGripClosed: grip_closed_q <= cfg_data_i[AngleW-1:0];
        CfgSlideBot:   slide_bot_q   <= cfg_data_i[AngleW-1:0];
        CfgSlideTop:   slide_top_q   <= cfg_data_i[AngleW-1:0];
        CfgSlideMid:   slide_mid_q   <= cfg_data_i[AngleW-1:0];
        CfgTolerance:  tol_q         <= cfg_data_i[TolW-1:0];
        CfgTimeout:    timeout_q     <= cfg_data_i[TickW-1:0];
        default: ;
      endcase
    end
  end

  // next state: executor first, then checker on the updated state
  always_comb begin
    exec_d   = exec_q;
    seq_d    = seq_q;
    step_d   = step_q;
    check_d  = check_q;
    target_d = target_q;
    tick_d   = tick_q;
    servo_d  = servo_q;
    issued   = 1'b0;
    mv       = MvOpen;
    mv_servo = ServoGripper;
    mv_target = '0;
    diff     = '0;
    abs_diff = '0;

    if (in_kind == KindCommand) begin
      if (exec_q != ExActive && in_sel != SeqNone) begin
        seq_d  = seq_e'(in_sel);
        step_d = 2'd0;
        exec_d = ExActive;
      end
    end else begin
      if (exec_q == ExActive) begin
        unique case (check_q)
          CkWaiting, CkConfirmed: begin
            if (check_q == CkConfirmed &&
                ({2'b00, step_q} + 4'd1) >= seq_length(seq_q)) begin
              exec_d   = ExDone;
              check_d  = CkWaiting;
              target_d = '0;
              tick_d   = '0;
              servo_d  = ServoGripper;
            end else begin
              if (check_q == CkConfirmed) step_d = step_q + 2'd1;
              mv = seq_move(seq_q, step_d);
              unique case (mv)
                MvOpen:  begin mv_servo = ServoGripper; mv_target = grip_open_q;   end
                MvClose: begin mv_servo = ServoGripper; mv_target = grip_closed_q; end
                MvLower: begin mv_servo = ServoSlider;  mv_target = slide_bot_q;   end
                MvLift:  begin mv_servo = ServoSlider;  mv_target = slide_top_q;   end
                default: begin mv_servo = ServoSlider;  mv_target = slide_mid_q;   end
              endcase
              check_d  = CkWaiting;
              target_d = '0;
              tick_d   = '0;
              servo_d  = ServoGripper;
              if (!in_pre_ok || !in_set_ok) begin
                exec_d = ExRetries;
              end else begin
                servo_d  = mv_servo;
                target_d = mv_target;
                check_d  = CkActive;
                issued   = 1'b1;
              end
            end
          end
          CkActive: ;
          CkReadFail: begin
            exec_d   = ExRetries;
            check_d  = CkWaiting;
            target_d = '0;
            tick_d   = '0;
            servo_d  = ServoGripper;
          end
          default: begin
            exec_d   = ExWrongPos;
            check_d  = CkWaiting;
            target_d = '0;
            tick_d   = '0;
            servo_d  = ServoGripper;
          end
        endcase
      end

      if (check_d == CkActive) begin
        if (tick_d != '1) tick_d = tick_d + TickW'(1);
        diff = $signed({2'b00, target_d, 4'b0000}) - $signed({2'b00, in_meas});
        abs_diff = diff[MeasW+1] ? (MeasW+1)'(0) - diff[MeasW:0] : diff[MeasW:0];
        if (!in_rd_ok) begin
          check_d = CkReadFail;
        end else if (abs_diff < {4'b0000, tol_q}) begin
          check_d = CkConfirmed;
        end else if (tick_d >= timeout_q) begin
          check_d = CkTimeout;
        end
      end
    end
  end

  assign out_valid_d = in_fire || (out_valid_q && !m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exec_q      <= ExIdle;
      seq_q       <= SeqTake;
      step_q      <= '0;
      check_q     <= CkWaiting;
      target_q    <= '0;
      tick_q      <= '0;
      servo_q     <= ServoGripper;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire) begin
        exec_q   <= exec_d;
        seq_q    <= seq_d;
        step_q   <= step_d;
        check_q  <= check_d;
        target_q <= target_d;
        tick_q   <= tick_d;
        servo_q  <= servo_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_exec_q   <= exec_d;
      out_check_q  <= check_d;
      out_issued_q <= issued;
      out_servo_q  <= servo_d;
      out_target_q <= target_d;
      out_step_q   <= step_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_step_q, out_target_q, out_servo_q, out_issued_q,
                          out_check_q, out_exec_q};

  // checker is only loaded while the executor runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_q != ExActive |-> check_q == CkWaiting)
    else $error("checker not waiting outside an active sequence");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    check_q == CkWaiting |-> (target_q == '0 && servo_q == ServoGripper && tick_q == '0))
    else $error("waiting checker holds a move");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({2'b00, step_q} < seq_length(seq_q)))
    else $error("step index beyond sequence length");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_issued_q) |-> (out_check_q != CkWaiting && out_exec_q == ExActive))
    else $error("issued move without an active check");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_kind == KindCommand) |=> (check_q == $past(check_q)))
    else $error("command changed checker state");

endmodule

`default_nettype wire
